// ----- hdl/srsa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the snapshot ring storage allocator.
// No dependencies; imported by every module of the block.
package srsa_pkg;

  // Frame ring and store geometry (FRAME_SLOTS must be a power of two)
  localparam int FRAME_SLOTS = 64;
  localparam int MAX_STORE   = 16384;
  localparam int MAX_REQUEST = 1024;

  localparam int SLOT_W  = $clog2(FRAME_SLOTS);
  localparam int CNT_W   = 15;
  localparam int POS_W   = 14;
  localparam int FRAME_W = 32;
  localparam int REQ_W   = 11;
  localparam int REL_W   = $clog2(FRAME_SLOTS + 1);

  // Largest frame distance that still leaves the ring with a free slot
  localparam logic [FRAME_W-1:0] SLOT_LAST = FRAME_W'(FRAME_SLOTS - 1);

  // Request codes
  typedef enum logic {
    REQ_ALLOC  = 1'b0,
    REQ_REINIT = 1'b1
  } req_code_t;

  typedef struct packed {
    logic             req_type;
    logic [REQ_W-1:0] request_count;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]   start_position;
    logic [FRAME_W-1:0] frame_number;
    logic [FRAME_W-1:0] oldest_valid;
    logic [REL_W-1:0]   frames_released;
    logic [CNT_W-1:0]   free_after;
    logic               shortfall_error;
  } out_t;

  // Command bundle from the sequencer to the slot count store
  typedef struct packed {
    logic              clear_all;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;
  } slot_cmd_t;

  // Effective store size: zero acts as one, oversize saturates
  function automatic logic [CNT_W-1:0] size_clamp(input logic [CNT_W-1:0] t);
    logic [CNT_W-1:0] r;
    r = t;
    if (t == '0) r = CNT_W'(1);
    if (t > CNT_W'(MAX_STORE)) r = CNT_W'(MAX_STORE);
    return r;
  endfunction

endpackage

// ----- hdl/srsa_slot_store.sv -----
`timescale 1ns / 1ps
// Per-slot entry counts: one synchronous memory plus a valid bit per slot.
// Depends on srsa_pkg. A read retires the slot (its valid bit drops).
module srsa_slot_store (
  input  logic                       clk,
  input  logic                       rst,
  input  srsa_pkg::slot_cmd_t        cmd,
  output logic [srsa_pkg::CNT_W-1:0] rd_data
);
  import srsa_pkg::*;

  logic [CNT_W-1:0]       mem [FRAME_SLOTS];
  logic [FRAME_SLOTS-1:0] valid;
  logic [CNT_W-1:0]       rd_q;
  logic                   rd_vld;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_q   <= mem[cmd.rd_addr];
      rd_vld <= valid[cmd.rd_addr];
    end
  end

  // Valid bits: a never-written or retired slot reads as zero
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      valid <= '0;
    end else begin
      if (cmd.rd_en) valid[cmd.rd_addr] <= 1'b0;
      if (cmd.wr_en) valid[cmd.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ----- hdl/snapshot_ring_storage_allocator_core.sv -----
`timescale 1ns / 1ps
// Top level of the snapshot ring storage allocator: request sequencer and result register.
// Depends on srsa_pkg and srsa_slot_store.

// Takes one request at a time. An allocate request runs through ST_FULL, ST_RELEASE,
// ST_COMMIT, ST_WRAP and ST_RESULT, staying in ST_RELEASE while the release loop retires
// frames (at most FRAME_SLOTS - 1). The oldest frame of a full ring needs no pass of the
// loop, because its slot is read in the same cycle as the ring check. The release loop reads
// one slot count per cycle from the slot store and folds it into the free count in the next.
// A shortfall skips ST_WRAP. A reinitialize request goes straight to ST_RESULT. A result that
// the receiver does not take adds its wait. The result sits in an output register, so the
// next request is taken while it waits. Writing total_entries also clears all storage at once
// and holds off requests for that cycle; there is no clearing pass.
module snapshot_ring_storage_allocator_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  srsa_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output srsa_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic [srsa_pkg::CNT_W-1:0] cfg_data
);
  import srsa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FULL,
    ST_RELEASE,
    ST_COMMIT,
    ST_WRAP,
    ST_RESULT
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   total_entries;
  logic [CNT_W-1:0]   free_entries;
  logic [POS_W-1:0]   write_position;
  logic [FRAME_W-1:0] next_frame;
  logic [FRAME_W-1:0] oldest_frame;
  logic [REQ_W-1:0]   req_count;
  logic [REL_W-1:0]   released;
  logic               pend;
  logic [CNT_W-1:0]   wrap_sum;
  out_t               res;

  slot_cmd_t          cmd;
  logic [CNT_W-1:0]   rd_data;

  logic [CNT_W-1:0]   size;
  logic [SLOT_W-1:0]  cur_slot;
  logic               ring_full;
  logic [CNT_W:0]     free_sum;
  logic [CNT_W-1:0]   free_now;
  logic               cont;
  logic               short;
  logic [CNT_W-1:0]   wrap_sub;
  logic [CNT_W-1:0]   wrap_pos;
  logic               in_acc;
  logic [REQ_W-1:0]   count_sat;

  srsa_slot_store u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_data (rd_data)
  );

  assign in_ready = (state == ST_IDLE) && !cfg_we;
  assign in_acc   = in_valid && in_ready;
  assign size     = size_clamp(total_entries);
  assign cur_slot = next_frame[SLOT_W-1:0];

  // Saturate the entry count
  assign count_sat = (in_data.request_count > REQ_W'(MAX_REQUEST)) ?
                     REQ_W'(MAX_REQUEST) : in_data.request_count;

  // Ring full check: the oldest frame shares the new slot
  assign ring_full = (next_frame - oldest_frame) > SLOT_LAST;

  // Release loop: fold in the slot read last cycle, then decide on another retirement
  assign free_sum = {1'b0, free_entries} + {1'b0, (pend ? rd_data : {CNT_W{1'b0}})};
  assign free_now = free_sum[CNT_W-1:0];
  assign cont     = (free_now < CNT_W'(req_count)) && (oldest_frame != next_frame);
  assign short    = free_entries < CNT_W'(req_count);

  // Write position wrap: compare-and-subtract, then a guard for tiny stores
  assign wrap_sub = wrap_sum - size;
  always_comb begin
    wrap_pos = (wrap_sum >= size) ? wrap_sub : wrap_sum;
    if (wrap_pos >= size) wrap_pos = '0;
  end

  // Slot store commands
  always_comb begin
    cmd           = '0;
    cmd.clear_all = cfg_we || (in_acc && in_data.req_type == REQ_REINIT);
    unique case (state)
      ST_FULL: begin
        cmd.rd_en   = ring_full;
        cmd.rd_addr = cur_slot;
      end
      ST_RELEASE: begin
        cmd.rd_en   = cont;
        cmd.rd_addr = oldest_frame[SLOT_W-1:0];
      end
      ST_COMMIT: begin
        cmd.wr_en   = !short;
        cmd.wr_addr = cur_slot;
        cmd.wr_data = CNT_W'(req_count);
      end
      default: ;
    endcase
  end

  // Sequencer, state registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      total_entries  <= CNT_W'(MAX_STORE);
      free_entries   <= CNT_W'(MAX_STORE);
      write_position <= '0;
      next_frame     <= '0;
      oldest_frame   <= '0;
      pend           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // Output register: load a finished result once the previous one has gone
      if (state == ST_RESULT && (!out_valid || out_ready)) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        // Register write also reinitialises the storage
        total_entries  <= cfg_data;
        free_entries   <= size_clamp(cfg_data);
        write_position <= '0;
        next_frame     <= '0;
        oldest_frame   <= '0;
      end else begin
        unique case (state)
          ST_IDLE: begin
            if (in_acc) begin
              req_count <= count_sat;
              released  <= '0;
              pend      <= 1'b0;
              if (in_data.req_type == REQ_REINIT) begin
                free_entries        <= size;
                write_position      <= '0;
                next_frame          <= '0;
                oldest_frame        <= '0;
                res.start_position  <= '0;
                res.frame_number    <= '0;
                res.oldest_valid    <= '0;
                res.frames_released <= '0;
                res.free_after      <= size;
                res.shortfall_error <= 1'b0;
                state               <= ST_RESULT;
              end else begin
                state <= ST_FULL;
              end
            end
          end
          ST_FULL: begin
            if (ring_full) begin
              oldest_frame <= next_frame - SLOT_LAST;
              released     <= REL_W'(1);
              pend         <= 1'b1;
            end
            state <= ST_RELEASE;
          end
          ST_RELEASE: begin
            free_entries <= free_now;
            if (cont) begin
              oldest_frame <= oldest_frame + FRAME_W'(1);
              released     <= released + REL_W'(1);
              pend         <= 1'b1;
            end else begin
              pend  <= 1'b0;
              state <= ST_COMMIT;
            end
          end
          ST_COMMIT: begin
            if (short) begin
              res.start_position  <= '0;
              res.frame_number    <= '0;
              res.oldest_valid    <= oldest_frame;
              res.frames_released <= released;
              res.free_after      <= free_entries;
              res.shortfall_error <= 1'b1;
              state               <= ST_RESULT;
            end else begin
              free_entries <= free_entries - CNT_W'(req_count);
              wrap_sum     <= CNT_W'(write_position) + CNT_W'(req_count);
              next_frame   <= next_frame + FRAME_W'(1);
              state        <= ST_WRAP;
            end
          end
          ST_WRAP: begin
            res.start_position  <= write_position;
            res.frame_number    <= next_frame - FRAME_W'(1);
            res.oldest_valid    <= oldest_frame;
            res.frames_released <= released;
            res.free_after      <= free_entries;
            res.shortfall_error <= 1'b0;
            write_position      <= wrap_pos[POS_W-1:0];
            state               <= ST_RESULT;
          end
          ST_RESULT: begin
            if (!out_valid || out_ready) state <= ST_IDLE;
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  // Checks on the allocator's own bookkeeping
  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    (next_frame - oldest_frame) <= FRAME_W'(FRAME_SLOTS))
    else $error("frame ring holds more frames than slots");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_entries <= size)
    else $error("free count exceeds store size");

  a_wpos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (CNT_W'(write_position) < size))
    else $error("write position outside the store");

  a_release_bound: assert property (@(posedge clk) disable iff (rst)
    released <= REL_W'(FRAME_SLOTS) || state == ST_IDLE)
    else $error("more frames retired than slots exist");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("request taken while another is in progress");

endmodule
